FILE: src/iia_pkg.sv
// Package for the iterative integer ALU.
// Holds opcodes, transaction structs and the sequencer-to-datapath control struct.
// No dependencies.
package iia_pkg;

    localparam int OPCODE_W  = 3;
    localparam int OPERAND_W = 31;
    localparam int RESULT_W  = 32;

    typedef logic [OPCODE_W-1:0] opcode_t;

    localparam opcode_t OP_ADD = 3'd0;
    localparam opcode_t OP_SUB = 3'd1;
    localparam opcode_t OP_MUL = 3'd2;
    localparam opcode_t OP_DIV = 3'd3;
    localparam opcode_t OP_REM = 3'd4;

    typedef struct packed {
        opcode_t                opcode;
        logic [OPERAND_W-1:0]   operand_a;
        logic [OPERAND_W-1:0]   operand_b;
    } cmd_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_value;
        logic                       result_zero;
        logic                       divide_by_zero;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctrl_t;

endpackage

FILE: src/iia_seq.sv
// Sequencer of the iterative integer ALU: handshake, step counter, done strobe.
// Depends on iia_pkg.
module iia_seq #(
    parameter int DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  iia_pkg::opcode_t  opcode,
    output logic              busy,
    output logic              done,
    output iia_pkg::ctrl_t    ctrl
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic               is_iter;

    assign is_iter = (opcode == iia_pkg::OP_MUL) || (opcode == iia_pkg::OP_DIV)
                     || (opcode == iia_pkg::OP_REM);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        ctrl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    state_next = is_iter ? S_RUN : S_DONE;
                end
            end
            S_RUN:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                ctrl.finish = 1'b1;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

FILE: src/iia_datapath.sv
// Datapath of the iterative integer ALU: operand registers and one shared adder/subtractor
// used for add, subtract, shift-add multiply and restoring divide. Depends on iia_pkg.
module iia_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic            clk,
    input  iia_pkg::cmd_t   cmd,
    input  iia_pkg::ctrl_t  ctrl,
    output iia_pkg::rsp_t   rsp
);

    localparam int W = DATA_WIDTH;

    iia_pkg::opcode_t   op_reg, op_next;
    logic [W-1:0]       x_reg, x_next;
    logic [W-1:0]       y_reg, y_next;
    logic [W-1:0]       acc_reg, acc_next;
    iia_pkg::rsp_t      rsp_reg, rsp_next;

    logic [W-1:0]       a_ld, b_ld;
    logic [W:0]         add_a, add_b;
    logic               add_inv;
    logic [W+1:0]       sum;
    logic               ge;
    logic [W-1:0]       res;
    logic               dz;

    always_comb
    begin
        a_ld = '0;
        b_ld = '0;
        for (int i = 0; i < W; i++)
        begin
            if (i < iia_pkg::OPERAND_W)
            begin
                a_ld[i] = cmd.operand_a[i];
                b_ld[i] = cmd.operand_b[i];
            end
        end
    end

    // shared adder: W+2 bits so the sign bit gives the divide compare
    always_comb
    begin
        add_a   = {1'b0, x_reg};
        add_b   = {1'b0, y_reg};
        add_inv = (op_reg == iia_pkg::OP_SUB);
        if (ctrl.step)
        begin
            if (op_reg == iia_pkg::OP_MUL)
            begin
                add_a   = {1'b0, acc_reg};
                add_b   = {1'b0, x_reg};
                add_inv = 1'b0;
            end
            else
            begin
                add_a   = {acc_reg, x_reg[W-1]};
                add_b   = {1'b0, y_reg};
                add_inv = 1'b1;
            end
        end
    end

    assign sum = {1'b0, add_a} + (add_inv ? ~{1'b0, add_b} : {1'b0, add_b})
                 + (W+2)'(add_inv);
    assign ge  = ~sum[W+1];

    always_comb
    begin
        res = '0;
        dz  = 1'b0;
        unique case (op_reg)
            iia_pkg::OP_ADD,
            iia_pkg::OP_SUB: res = sum[W-1:0];
            iia_pkg::OP_MUL: res = acc_reg;
            iia_pkg::OP_DIV:
            begin
                dz  = (y_reg == '0);
                res = dz ? '0 : x_reg;
            end
            iia_pkg::OP_REM:
            begin
                dz  = (y_reg == '0);
                res = dz ? '0 : acc_reg;
            end
            default: res = '0;
        endcase
    end

    always_comb
    begin
        op_next  = op_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        acc_next = acc_reg;
        rsp_next = rsp_reg;
        if (ctrl.load)
        begin
            op_next  = cmd.opcode;
            x_next   = a_ld;
            y_next   = b_ld;
            acc_next = '0;
        end
        else if (ctrl.step)
        begin
            if (op_reg == iia_pkg::OP_MUL)
            begin
                acc_next = y_reg[0] ? sum[W-1:0] : acc_reg;
                x_next   = {x_reg[W-2:0], 1'b0};
                y_next   = {1'b0, y_reg[W-1:1]};
            end
            else
            begin
                acc_next = ge ? sum[W-1:0] : add_a[W-1:0];
                x_next   = {x_reg[W-2:0], ge};
            end
        end
        else if (ctrl.finish)
        begin
            for (int i = 0; i < iia_pkg::RESULT_W; i++)
                rsp_next.result_value[i] = (i < W) ? res[i] : res[W-1];
            rsp_next.result_zero    = (res == '0);
            rsp_next.divide_by_zero = dz;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

FILE: src/iterative_integer_alu.sv
// Iterative integer ALU: add, subtract, multiply, divide, remainder on one shared adder.
// Multiply, divide and remainder go through load, one shift-add or shift-subtract step per bit
// and finish; add, subtract and the other opcodes go from load straight to finish.
// A new transaction is taken only while idle; busy is high while working.
// The done strobe lasts one cycle and cannot be stalled. Reset clears the sequencer only.
module iterative_integer_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  iia_pkg::cmd_t   cmd,
    output logic            done,
    output iia_pkg::rsp_t   rsp
);

    iia_pkg::ctrl_t ctrl;

    iia_seq #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (cmd.opcode),
        .busy   (busy),
        .done   (done),
        .ctrl   (ctrl)
    );

    iia_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk  (clk),
        .cmd  (cmd),
        .ctrl (ctrl),
        .rsp  (rsp)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the iterative integer ALU: random and edge-case commands,
// scoreboard class with a local result predictor. Depends on iia_pkg and the
// iterative_integer_alu top level.
`timescale 1ns / 100ps

module testbench;

    localparam int DW            = 32;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_ITEMS  = 500;
    localparam logic [iia_pkg::OPERAND_W-1:0] MAX_OPERAND = '1;

    class alu_scoreboard;
        iia_pkg::rsp_t pending_results[$];
        iia_pkg::cmd_t pending_cmds[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function iia_pkg::rsp_t alu_result(iia_pkg::cmd_t c);
            logic [63:0]   m;
            logic [63:0]   a;
            logic [63:0]   b;
            logic [63:0]   r;
            logic [63:0]   sign_bit;
            logic [63:0]   v;
            logic          dz;
            iia_pkg::rsp_t p;
            m  = (DW >= 64) ? '1 : ((64'd1 << DW) - 64'd1);
            a  = {33'd0, c.operand_a} & m;
            b  = {33'd0, c.operand_b} & m;
            r  = '0;
            dz = 1'b0;
            case (c.opcode)
                iia_pkg::OP_ADD: r = a + b;
                iia_pkg::OP_SUB: r = a - b;
                iia_pkg::OP_MUL: r = a * b;
                iia_pkg::OP_DIV:
                begin
                    if (b == 0) dz = 1'b1;
                    else r = a / b;
                end
                iia_pkg::OP_REM:
                begin
                    if (b == 0) dz = 1'b1;
                    else r = a % b;
                end
                default: r = '0;
            endcase
            r = r & m;
            if (DW < 32)
            begin
                sign_bit = 64'd1 << (DW - 1);
                v = (r ^ sign_bit) - sign_bit;
                p.result_value = v[31:0];
            end
            else
            begin
                p.result_value = r[31:0];
            end
            p.result_zero    = (r == 0);
            p.divide_by_zero = dz;
            return p;
        endfunction

        function void note_command(iia_pkg::cmd_t c);
            pending_cmds.push_back(c);
            pending_results.push_back(alu_result(c));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_response(iia_pkg::rsp_t got);
            iia_pkg::rsp_t want;
            iia_pkg::cmd_t c;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result value=%0h", got.result_value));
                return;
            end
            want = pending_results.pop_front();
            c    = pending_cmds.pop_front();
            if (got.result_value !== want.result_value)
                report($sformatf("op=%0d a=%0h b=%0h result_value exp %0h got %0h",
                       c.opcode, c.operand_a, c.operand_b,
                       want.result_value, got.result_value));
            if (got.result_zero !== want.result_zero)
                report($sformatf("op=%0d a=%0h b=%0h result_zero exp %0b got %0b",
                       c.opcode, c.operand_a, c.operand_b,
                       want.result_zero, got.result_zero));
            if (got.divide_by_zero !== want.divide_by_zero)
                report($sformatf("op=%0d a=%0h b=%0h divide_by_zero exp %0b got %0b",
                       c.opcode, c.operand_a, c.operand_b,
                       want.divide_by_zero, got.divide_by_zero));
        endtask
    endclass

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    iia_pkg::cmd_t  cmd;
    logic           done;
    iia_pkg::rsp_t  rsp;

    alu_scoreboard board;
    int            idle_pct;
    int            idle_cycles;

    iterative_integer_alu #(
        .DATA_WIDTH (DW)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // accept and result monitor, plus watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_command(cmd);
            if (done)
                board.check_response(rsp);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function iia_pkg::cmd_t make_cmd(iia_pkg::opcode_t op,
                                     logic [iia_pkg::OPERAND_W-1:0] a,
                                     logic [iia_pkg::OPERAND_W-1:0] b);
        iia_pkg::cmd_t c;
        c.opcode    = op;
        c.operand_a = a;
        c.operand_b = b;
        return c;
    endfunction

    function logic [iia_pkg::OPERAND_W-1:0] random_operand(int shape);
        logic [iia_pkg::OPERAND_W-1:0] v;
        case (shape)
            0: v = iia_pkg::OPERAND_W'($urandom_range(0, 255));
            1: v = MAX_OPERAND - iia_pkg::OPERAND_W'($urandom_range(0, 15));
            2: v = '0;
            3: v = {{(iia_pkg::OPERAND_W-1){1'b0}}, 1'b1}
                   << $urandom_range(0, iia_pkg::OPERAND_W - 1);
            default: v = iia_pkg::OPERAND_W'($urandom);
        endcase
        return v;
    endfunction

    function iia_pkg::cmd_t random_command();
        iia_pkg::cmd_t c;
        int            pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            c.opcode = iia_pkg::opcode_t'($urandom_range(5, 7));
        else
            c.opcode = iia_pkg::opcode_t'($urandom_range(0, 4));
        c.operand_a = random_operand($urandom_range(0, 1) ? 4 : $urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            c.operand_b = '0;
        else if (pick < 30)
            c.operand_b = iia_pkg::OPERAND_W'($urandom_range(1, 15));
        else if (pick < 45)
            c.operand_b = random_operand($urandom_range(0, 3));
        else
            c.operand_b = iia_pkg::OPERAND_W'($urandom);
        return c;
    endfunction

    // on each try start idles with a chance of idle_pct percent, until the transaction is taken
    task send(iia_pkg::cmd_t c);
        logic accepted;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < idle_pct)
                start <= 1'b0;
            else
            begin
                start <= 1'b1;
                cmd   <= c;
            end
            @(posedge clk);
            accepted = start && !busy;
        end
    endtask

    task run_directed();
        send(make_cmd(iia_pkg::OP_ADD, '0, '0));
        send(make_cmd(iia_pkg::OP_ADD, MAX_OPERAND, MAX_OPERAND));
        send(make_cmd(iia_pkg::OP_SUB, '0, MAX_OPERAND));
        send(make_cmd(iia_pkg::OP_SUB, MAX_OPERAND, '0));
        send(make_cmd(iia_pkg::OP_SUB, 31'h1234_5678, 31'h1234_5678));
        send(make_cmd(iia_pkg::OP_SUB, '0, 31'd1));
        send(make_cmd(iia_pkg::OP_MUL, MAX_OPERAND, MAX_OPERAND));
        send(make_cmd(iia_pkg::OP_MUL, MAX_OPERAND, '0));
        send(make_cmd(iia_pkg::OP_MUL, '0, MAX_OPERAND));
        send(make_cmd(iia_pkg::OP_MUL, 31'h4000_0000, 31'd2));
        send(make_cmd(iia_pkg::OP_DIV, MAX_OPERAND, 31'd1));
        send(make_cmd(iia_pkg::OP_DIV, MAX_OPERAND, '0));
        send(make_cmd(iia_pkg::OP_DIV, '0, '0));
        send(make_cmd(iia_pkg::OP_DIV, 31'd5, 31'd9));
        send(make_cmd(iia_pkg::OP_DIV, MAX_OPERAND, MAX_OPERAND));
        send(make_cmd(iia_pkg::OP_DIV, '0, MAX_OPERAND));
        send(make_cmd(iia_pkg::OP_REM, MAX_OPERAND, '0));
        send(make_cmd(iia_pkg::OP_REM, MAX_OPERAND, 31'd7));
        send(make_cmd(iia_pkg::OP_REM, 31'd5, 31'd9));
        send(make_cmd(iia_pkg::OP_REM, MAX_OPERAND, MAX_OPERAND));
        send(make_cmd(iia_pkg::opcode_t'(5), MAX_OPERAND, MAX_OPERAND));
        send(make_cmd(iia_pkg::opcode_t'(6), 31'd1, 31'd1));
        send(make_cmd(iia_pkg::opcode_t'(7), MAX_OPERAND, '0));
    endtask

    initial
    begin
        int phase;
        board       = new();
        idle_cycles = 0;
        idle_pct    = 20;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 20 : (phase == 1) ? 61 : 0;
            repeat (RANDOM_ITEMS / 3) send(random_command());
        end

        @(negedge clk);
        start <= 1'b0;
        while (board.pending() > 0) @(posedge clk);
        repeat (DW + 4) @(posedge clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
